// File: hw/rtl/knock_retard_controller_macros.svh
// Assertion macros used by the knock retard controller top level.
`ifndef KNOCK_RETARD_CONTROLLER_MACROS_SVH
`define KNOCK_RETARD_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, reset disables the check
`define KRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset disables the check
`define KRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define KRC_ASSERT_NOW(lbl, ante, cons, msg)
`define KRC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/krc_pkg.sv
// Package: types, widths and constants of the knock retard controller.
`default_nettype none

package krc_pkg;

	// Field widths
	localparam int AggrW    = 7;
	localparam int RecovW   = 10;
	localparam int WindowW  = 16;
	localparam int LevelW   = 15;
	localparam int GainW    = 13;
	localparam int TimingW  = 14;
	localparam int AngleW   = 13;
	localparam int CountW   = 32;
	localparam int CfgDataW = 16;
	localparam int CfgIdxW  = 2;

	// Step product: (timing + offset) * aggression, signed
	localparam int DistW    = TimingW + 1;
	localparam int ProdW    = DistW + AggrW + 1;
	localparam int MagW     = 21;
	localparam int QuotW    = 14;
	localparam int SumW     = 16;

	localparam logic signed [DistW-1:0] TimingOffset = 15'sd2000;
	localparam logic [WindowW-1:0]      TickSat      = '1;

	// Divide by 100: q = (n * DivMul) >> DivShift, exact for n below 1864135
	// (error term 72 * n stays below 2^27 for |product| <= 1294257)
	localparam int DivShift = 27;
	localparam logic [MagW-1:0] DivMul = 21'd1342178;

	// Reset values of the configuration registers
	localparam logic [AggrW-1:0]   AggrReset   = 7'd10;
	localparam logic [RecovW-1:0]  RecovReset  = 10'd1;
	localparam logic [WindowW-1:0] WindowReset = 16'd100;

	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_TICK   = 1'b1
	} krc_func_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_AGGRESSION = 2'd0,
		REG_RECOVERY   = 2'd1,
		REG_WINDOW     = 2'd2
	} krc_reg_t;

	// One word after the input register
	typedef struct packed {
		krc_func_t                 func;
		logic signed [LevelW-1:0]  knock_level;
		logic signed [GainW-1:0]   gain_adjust;
		logic signed [ProdW-1:0]   step_product;
		logic signed [LevelW-1:0]  new_threshold;
		logic [AngleW-1:0]         new_max_retard;
	} krc_item_t;

	// Controller state
	typedef struct packed {
		logic [AngleW-1:0]         retard_now;
		logic [CountW-1:0]         knock_total;
		logic signed [LevelW-1:0]  threshold_now;
		logic [AngleW-1:0]         max_retard_now;
		logic [WindowW-1:0]        ticks_since_knock;
		logic                      recent_flag;
		logic                      active_flag;
	} krc_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/krc_update.sv
// State update for one word: knock detect, retard step and clamp, tick recovery.
`default_nettype none

module krc_update
	import krc_pkg::*;
(
	input  krc_item_t          item,
	input  krc_state_t         st,
	input  logic [RecovW-1:0]  recovery_per_tick,
	input  logic [WindowW-1:0] recent_window_ticks,
	output krc_state_t         st_next,
	output logic               knock
);

	logic signed [SumW-1:0]  level;
	logic                    step_neg;
	logic [ProdW-1:0]        prod_abs;
	logic [MagW-1:0]         step_mag;
	logic [2*MagW-1:0]       recip_prod;
	logic [QuotW-1:0]        quot;
	logic signed [SumW-1:0]  amount;
	logic signed [SumW-1:0]  sum;
	logic [AngleW-1:0]       knock_retard;
	logic [AngleW-1:0]       tick_retard;
	logic [WindowW-1:0]      ticks_inc;

	// Level plus cylinder gain against the stored threshold
	assign level = SumW'(item.knock_level) + SumW'(item.gain_adjust);
	assign knock = (item.func == FUNC_SAMPLE) && (level > SumW'(st.threshold_now));

	// Step size: product / 100, truncated toward zero
	assign step_neg   = item.step_product[ProdW-1];
	assign prod_abs   = step_neg ? (-item.step_product) : item.step_product;
	assign step_mag   = prod_abs[MagW-1:0];
	assign recip_prod = (2*MagW)'(step_mag) * (2*MagW)'(DivMul);
	assign quot       = recip_prod[DivShift+QuotW-1:DivShift];
	assign amount     = step_neg ? -SumW'(quot) : SumW'(quot);

	// New retard after knock, clamped to 0..max
	assign sum = SumW'(st.retard_now) + amount;
	always_comb begin
		if (sum < 0) begin
			knock_retard = '0;
		end else if (sum > SumW'(st.max_retard_now)) begin
			knock_retard = st.max_retard_now;
		end else begin
			knock_retard = sum[AngleW-1:0];
		end
	end

	// Tick recovery, floored at zero; saturating tick count
	assign tick_retard = (st.retard_now > AngleW'(recovery_per_tick)) ?
		(st.retard_now - AngleW'(recovery_per_tick)) : '0;
	assign ticks_inc = (st.ticks_since_knock != TickSat) ?
		(st.ticks_since_knock + 1'b1) : st.ticks_since_knock;

	// Next state
	always_comb begin
		st_next = st;
		if (item.func == FUNC_TICK) begin
			st_next.retard_now        = tick_retard;
			st_next.ticks_since_knock = ticks_inc;
			st_next.recent_flag       = (ticks_inc < recent_window_ticks);
			st_next.active_flag       = (tick_retard != '0);
			st_next.threshold_now     = item.new_threshold;
			st_next.max_retard_now    = item.new_max_retard;
		end else if (knock) begin
			st_next.retard_now        = knock_retard;
			st_next.knock_total       = st.knock_total + 1'b1;
			st_next.ticks_since_knock = '0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/knock_retard_controller.sv
// Top level of the knock retard controller: handshake, registers and config port.
//
//  channel   signals                                   role
//  -------   ---------------------------------------   -----------------------------
//  in        in_valid/in_ready + six payload ports     sample or tick word in
//  out       out_valid/out_ready + five payload ports  one result word per input word
//  cfg       cfg_we, cfg_index, cfg_wdata              register write, no wait
//
// One word per cycle sustained while out_ready is high; the result is registered.
// The step product (timing + 20 deg) * aggression is formed ahead of the input register;
// divide by 100, clamp and state update sit between the input and result registers.
// A stalled result holds the input register; in_ready stays high while a word can move.
// Reset clears state and valid flags (tick count saturates) and loads config defaults.
`default_nettype none

`include "knock_retard_controller_macros.svh"

module knock_retard_controller
	import krc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic signed [LevelW-1:0] knock_level,
	input  logic signed [GainW-1:0]  gain_adjust,
	input  logic signed [TimingW-1:0] base_timing,
	input  logic signed [LevelW-1:0] new_threshold,
	input  logic [AngleW-1:0]        new_max_retard,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     is_knock,
	output logic [AngleW-1:0]        retard,
	output logic [CountW-1:0]        knock_count,
	output logic                     knock_recent,
	output logic                     retard_active,

	input  logic                     cfg_we,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgDataW-1:0]      cfg_wdata
);

	logic [AggrW-1:0]        aggression_q;
	logic [RecovW-1:0]       recovery_q;
	logic [WindowW-1:0]      window_q;

	logic                    valid_s1;
	krc_item_t               item_s1;
	logic                    out_valid_q;
	logic                    is_knock_q;
	krc_state_t              st_q;
	krc_state_t              st_next;
	logic                    knock_now;

	logic                    advance;
	logic                    in_take;
	logic                    fire_s1;
	logic signed [DistW-1:0] timing_dist;
	logic signed [ProdW-1:0] step_product;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aggression_q <= AggrReset;
			recovery_q   <= RecovReset;
			window_q     <= WindowReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AGGRESSION: aggression_q <= cfg_wdata[AggrW-1:0];
				REG_RECOVERY:   recovery_q   <= cfg_wdata[RecovW-1:0];
				REG_WINDOW:     window_q     <= cfg_wdata[WindowW-1:0];
				default: ;
			endcase
		end
	end

	// Handshake
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;
	assign fire_s1  = valid_s1 && advance;

	// Step product ahead of the input register
	assign timing_dist  = DistW'(base_timing) + TimingOffset;
	assign step_product = ProdW'(timing_dist) * ProdW'($signed({1'b0, aggression_q}));

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.func           <= krc_func_t'(func);
			item_s1.knock_level    <= knock_level;
			item_s1.gain_adjust    <= gain_adjust;
			item_s1.step_product   <= step_product;
			item_s1.new_threshold  <= new_threshold;
			item_s1.new_max_retard <= new_max_retard;
		end
	end

	krc_update u_update (
		.item                (item_s1),
		.st                  (st_q),
		.recovery_per_tick   (recovery_q),
		.recent_window_ticks (window_q),
		.st_next             (st_next),
		.knock               (knock_now)
	);

	// State and result register; state doubles as the result payload, is_knock apart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{
				retard_now:        '0,
				knock_total:       '0,
				threshold_now:     '0,
				max_retard_now:    '0,
				ticks_since_knock: TickSat,
				recent_flag:       1'b0,
				active_flag:       1'b0
			};
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			is_knock_q <= knock_now;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_knock      = is_knock_q;
	assign retard        = st_q.retard_now;
	assign knock_count   = st_q.knock_total;
	assign knock_recent  = st_q.recent_flag;
	assign retard_active = st_q.active_flag;

	// Checks
	`KRC_ASSERT_NEXT(a_count_step, fire_s1,
		st_q.knock_total == $past(st_q.knock_total) + CountW'($past(knock_now)),
		"knock count moved by other than the knock flag")
	`KRC_ASSERT_NEXT(a_state_hold, !fire_s1, $stable(st_q),
		"state changed with no word moving")
	`KRC_ASSERT_NEXT(a_tick_no_knock, fire_s1 && (item_s1.func == FUNC_TICK), !is_knock_q,
		"tick word flagged as knock")
	`KRC_ASSERT_NEXT(a_tick_active, fire_s1 && (item_s1.func == FUNC_TICK),
		st_q.active_flag == (st_q.retard_now != '0),
		"active flag disagrees with retard after tick")
	`KRC_ASSERT_NOW(a_fire_result, fire_s1, advance && valid_s1,
		"word left input register without room in result register")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench of the knock retard controller: directed table, then random phases.
module testbench;
	import krc_pkg::*;

	localparam int RunLimit         = 1_000_000;
	localparam int TimingOffsetCdeg = 2000;
	localparam int LongHoldCycles   = 40;
	localparam int DirectedWords    = 16;
	localparam int NumPhases        = 7;
	localparam int PhaseWords       = 148;
	localparam int RandomPhase      = 5;
	localparam int MaxReported      = 10;

	// register settings, idling and long hold per random phase
	localparam int PhaseAggr   [NumPhases] = '{10, 100, 0, 127, 50, 0, 100};
	localparam int PhaseRecov  [NumPhases] = '{1, 1000, 0, 1023, 5, 0, 0};
	localparam int PhaseWindow [NumPhases] = '{100, 0, 65535, 1, 20, 0, 3};
	localparam int PhaseIdleIn [NumPhases] = '{1, 0, 1, 0, 1, 1, 1};
	localparam int PhaseIdleOut[NumPhases] = '{1, 0, 0, 1, 1, 1, 0};
	localparam int PhaseHold   [NumPhases] = '{0, 1, 0, 0, 0, 1, 0};

	typedef struct packed {
		krc_func_t                func;
		logic signed [LevelW-1:0]  knock_level;
		logic signed [GainW-1:0]   gain_adjust;
		logic signed [TimingW-1:0] base_timing;
		logic signed [LevelW-1:0]  new_threshold;
		logic [AngleW-1:0]         new_max_retard;
	} sensor_word_t;

	typedef struct packed {
		logic              is_knock;
		logic [AngleW-1:0] retard;
		logic [CountW-1:0] knock_count;
		logic              knock_recent;
		logic              retard_active;
	} retard_result_t;

	typedef struct {
		sensor_word_t   w;
		bit             typed;
		retard_result_t want;
	} directed_row_t;

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      in_valid       = 1'b0;
	logic                      in_ready;
	logic                      func           = 1'b0;
	logic signed [LevelW-1:0]  knock_level    = '0;
	logic signed [GainW-1:0]   gain_adjust    = '0;
	logic signed [TimingW-1:0] base_timing    = '0;
	logic signed [LevelW-1:0]  new_threshold  = '0;
	logic [AngleW-1:0]         new_max_retard = '0;
	logic                      out_valid;
	logic                      out_ready      = 1'b0;
	logic                      is_knock;
	logic [AngleW-1:0]         retard;
	logic [CountW-1:0]         knock_count;
	logic                      knock_recent;
	logic                      retard_active;
	logic                      cfg_we         = 1'b0;
	logic [CfgIdxW-1:0]        cfg_index      = '0;
	logic [CfgDataW-1:0]       cfg_wdata      = '0;

	// controller state as predicted, starting from its reset values
	logic [AggrW-1:0]         ctl_aggression = AggrReset;
	logic [RecovW-1:0]        ctl_recovery   = RecovReset;
	logic [WindowW-1:0]       ctl_window     = WindowReset;
	logic [AngleW-1:0]        ctl_retard     = '0;
	logic [CountW-1:0]        ctl_knocks     = '0;
	logic signed [LevelW-1:0] ctl_threshold  = '0;
	logic [AngleW-1:0]        ctl_max_retard = '0;
	logic [WindowW-1:0]       ctl_ticks      = TickSat;
	logic                     ctl_recent     = 1'b0;
	logic                     ctl_active     = 1'b0;

	retard_result_t results_due[$];
	bit             idle_in  = 1'b0;
	bit             idle_out = 1'b0;
	int             holds_requested = 0;
	int             holds_done      = 0;
	int             check_failures  = 0;
	int             results_checked = 0;
	int             words_sent      = 0;
	int             ticks_seen      = 0;
	int             settings_used   = 0;
	int             input_stall_cycles = 0;

	knock_retard_controller uut (.*);

	always #1 clk = ~clk;

	// count cycles in which the controller pushed back on a waiting word
	always @(posedge clk) begin
		if (in_valid && !in_ready)
			input_stall_cycles++;
	end

	function automatic int unsigned idle_cycles(input bit enabled);
		return enabled ? $urandom_range(0, 7) : 0;
	endfunction

	// Applies one word to the predicted state and returns the result it should produce.
	function automatic retard_result_t advance_controller(input sensor_word_t w);
		retard_result_t r;
		int sum;
		int headroom;
		int delta;
		int updated;
		r.is_knock = 1'b0;
		if (w.func == FUNC_SAMPLE) begin
			sum = int'($signed(w.knock_level)) + int'($signed(w.gain_adjust));
			// strictly above threshold is knock
			if (sum > int'(ctl_threshold)) begin
				headroom = int'($signed(w.base_timing)) + TimingOffsetCdeg;
				delta    = (headroom * int'(ctl_aggression)) / 100;
				updated  = int'(ctl_retard) + delta;
				if (updated < 0)
					updated = 0;
				if (updated > int'(ctl_max_retard))
					updated = int'(ctl_max_retard);
				ctl_retard = AngleW'(updated);
				ctl_knocks = ctl_knocks + 1;
				ctl_ticks  = '0;
				r.is_knock = 1'b1;
			end
		end else begin
			// recovery, flags, then the new threshold and ceiling
			updated    = int'(ctl_retard) - int'(ctl_recovery);
			ctl_retard = (updated > 0) ? AngleW'(updated) : '0;
			if (ctl_ticks != TickSat)
				ctl_ticks = ctl_ticks + WindowW'(1);
			ctl_recent     = (ctl_ticks < ctl_window);
			ctl_active     = (ctl_retard != '0);
			ctl_threshold  = w.new_threshold;
			ctl_max_retard = w.new_max_retard;
			ticks_seen++;
		end
		r.retard        = ctl_retard;
		r.knock_count   = ctl_knocks;
		r.knock_recent  = ctl_recent;
		r.retard_active = ctl_active;
		return r;
	endfunction

	function automatic directed_row_t stim_row(input krc_func_t f, input int lvl, input int gain,
			input int tmg, input int thr, input int mx, input bit typed, input int k,
			input int ret, input int cnt, input int rec, input int act);
		directed_row_t r;
		r.w.func                = f;
		r.w.knock_level         = LevelW'(lvl);
		r.w.gain_adjust         = GainW'(gain);
		r.w.base_timing         = TimingW'(tmg);
		r.w.new_threshold       = LevelW'(thr);
		r.w.new_max_retard      = AngleW'(mx);
		r.typed                 = typed;
		r.want.is_knock         = k[0];
		r.want.retard           = AngleW'(ret);
		r.want.knock_count      = CountW'(cnt);
		r.want.knock_recent     = rec[0];
		r.want.retard_active    = act[0];
		return r;
	endfunction

	// Random word: mostly in range, levels clustered around the threshold, some full-width.
	function automatic sensor_word_t random_word();
		sensor_word_t w;
		int thr;
		thr    = int'(ctl_threshold);
		w.func = ($urandom_range(0, 9) < 3) ? FUNC_TICK : FUNC_SAMPLE;
		case ($urandom_range(0, 7))
			0: w.knock_level = LevelW'($urandom);
			1, 2: w.knock_level = LevelW'($signed($urandom_range(0, 20000)) - 10000);
			default: w.knock_level = LevelW'(thr + $signed($urandom_range(0, 400)) - 200);
		endcase
		case ($urandom_range(0, 7))
			0: w.gain_adjust = GainW'($urandom);
			1, 2: w.gain_adjust = GainW'($signed($urandom_range(0, 6000)) - 3000);
			default: w.gain_adjust = GainW'($signed($urandom_range(0, 100)) - 50);
		endcase
		if ($urandom_range(0, 7) == 0)
			w.base_timing = TimingW'($urandom);
		else
			w.base_timing = TimingW'($signed($urandom_range(0, 14400)) - 7200);
		case ($urandom_range(0, 7))
			0: w.new_threshold = LevelW'($urandom);
			1, 2, 3: w.new_threshold = LevelW'($signed($urandom_range(0, 600)) - 300);
			default: w.new_threshold = LevelW'($signed($urandom_range(0, 20000)) - 10000);
		endcase
		case ($urandom_range(0, 7))
			0: w.new_max_retard = AngleW'($urandom);
			1: w.new_max_retard = '0;
			default: w.new_max_retard = AngleW'($urandom_range(0, 6000));
		endcase
		return w;
	endfunction

	// Offer one word from a falling edge; predict its result once it is taken.
	task automatic offer_word(input sensor_word_t w, input bit use_typed,
			input retard_result_t typed);
		int unsigned gap;
		retard_result_t predicted;
		gap = idle_cycles(idle_in);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		func           <= w.func;
		knock_level    <= w.knock_level;
		gain_adjust    <= w.gain_adjust;
		base_timing    <= w.base_timing;
		new_threshold  <= w.new_threshold;
		new_max_retard <= w.new_max_retard;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = advance_controller(w);
		results_due.push_back(use_typed ? typed : predicted);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic write_register(input krc_reg_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CfgDataW'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_AGGRESSION: ctl_aggression = AggrW'(value);
			REG_RECOVERY:   ctl_recovery   = RecovW'(value);
			REG_WINDOW:     ctl_window     = WindowW'(value);
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
	endtask

	// Result side: random stalls, one long hold on request, check each word taken.
	initial begin : result_side
		int unsigned gap;
		retard_result_t got;
		retard_result_t want;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (holds_done != holds_requested) begin
				holds_done++;
				gap = LongHoldCycles;
			end else
				gap = idle_cycles(idle_out);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			got.is_knock      = is_knock;
			got.retard        = retard;
			got.knock_count   = knock_count;
			got.knock_recent  = knock_recent;
			got.retard_active = retard_active;
			if (results_due.size() == 0) begin
				check_failures++;
				if (check_failures <= MaxReported)
					$display("unexpected result word: knock=%0b retard=%0d count=%0d",
						got.is_knock, got.retard, got.knock_count);
			end else begin
				want = results_due.pop_front();
				results_checked++;
				if (got.is_knock !== want.is_knock || got.retard !== want.retard ||
						got.knock_count !== want.knock_count ||
						got.knock_recent !== want.knock_recent ||
						got.retard_active !== want.retard_active) begin
					check_failures++;
					if (check_failures <= MaxReported)
						$display({"mismatch on result %0d: expected knock=%0b retard=%0d ",
							"count=%0d recent=%0b active=%0b, got knock=%0b retard=%0d ",
							"count=%0d recent=%0b active=%0b"}, results_checked,
							want.is_knock, want.retard, want.knock_count, want.knock_recent,
							want.retard_active, got.is_knock, got.retard, got.knock_count,
							got.knock_recent, got.retard_active);
				end
			end
			@(negedge clk);
		end
	end

	// Word source: reset, directed table, then random phases with register changes.
	initial begin : word_source
		directed_row_t directed [DirectedWords];
		int p;
		int aggr;
		int recov;
		int window;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// widest window so a saturated tick counter is seen as not recent
		write_register(REG_WINDOW, 65535);
		settings_used++;
		idle_in  = 1'b1;
		idle_out = 1'b1;
		directed = '{
			// tick straight after reset: counter saturated, nothing recent
			stim_row(FUNC_TICK,        0,     0,     0,      0,    0, 1, 0,    0, 0, 0, 0),
			// knock with a zero ceiling leaves the retard at zero
			stim_row(FUNC_SAMPLE,      1,     0,     0,      0,    0, 1, 1,    0, 1, 0, 0),
			stim_row(FUNC_TICK,        0,     0,     0,      0, 6000, 1, 0,    0, 1, 1, 0),
			// upper ends of level, gain and timing
			stim_row(FUNC_SAMPLE,  10000,  3000,  7200,      0,    0, 1, 1,  920, 2, 1, 0),
			stim_row(FUNC_SAMPLE, -10000, -3000, -7200,      0,    0, 1, 0,  920, 2, 1, 0),
			// negative step pulls the retard down
			stim_row(FUNC_SAMPLE,    100,     0, -7200,      0,    0, 1, 1,  400, 3, 1, 0),
			// ceiling drops below the retard without clamping it
			stim_row(FUNC_TICK,        0,     0,     0,  10000,  300, 1, 0,  399, 3, 1, 1),
			// sum equal to threshold is not knock
			stim_row(FUNC_SAMPLE,  10000,     0,     0,      0,    0, 1, 0,  399, 3, 1, 1),
			// next knock clamps to the lowered ceiling
			stim_row(FUNC_SAMPLE,  10000,     1,     0,      0,    0, 1, 1,  300, 4, 1, 1),
			// full-width fields
			stim_row(FUNC_TICK,        0,     0,     0, -16384, 8191, 1, 0,  299, 4, 1, 1),
			stim_row(FUNC_SAMPLE, -16384, -4096,  8191,      0,    0, 1, 0,  299, 4, 1, 1),
			stim_row(FUNC_SAMPLE,  16383,  4095,  8191,  16383, 8191, 0, 0,    0, 0, 0, 0),
			// repeated negative steps until the retard floors at zero
			stim_row(FUNC_SAMPLE,  16383,     0, -8192, -16384,    0, 0, 0,    0, 0, 0, 0),
			stim_row(FUNC_SAMPLE,  16383,     0, -8192,      0, 8191, 0, 0,    0, 0, 0, 0),
			stim_row(FUNC_SAMPLE,  16383,     0, -8192,  16383,    0, 0, 0,    0, 0, 0, 0),
			stim_row(FUNC_TICK,    -1,      -1,    -1,       0, 6000, 0, 0,    0, 0, 0, 0)
		};
		foreach (directed[i])
			offer_word(directed[i].w, directed[i].typed, directed[i].want);
		wait_for_results();

		// random phases; registers change only with nothing in flight
		for (p = 0; p < NumPhases; p++) begin
			aggr   = PhaseAggr[p];
			recov  = PhaseRecov[p];
			window = PhaseWindow[p];
			if (p == RandomPhase) begin
				aggr   = $urandom_range(0, 127);
				recov  = $urandom_range(0, 1023);
				window = $urandom_range(0, 300);
			end
			write_register(REG_AGGRESSION, aggr);
			write_register(REG_RECOVERY, recov);
			write_register(REG_WINDOW, window);
			settings_used++;
			idle_in  = PhaseIdleIn[p] != 0;
			idle_out = PhaseIdleOut[p] != 0;
			if (PhaseHold[p] != 0)
				holds_requested++;
			repeat (PhaseWords)
				offer_word(random_word(), 1'b0, '0);
			wait_for_results();
		end

		repeat (8) @(negedge clk);
		$display("covered %0d words (%0d ticks, %0d knocks) under %0d register settings",
			words_sent, ticks_seen, ctl_knocks, settings_used);
		$display("checked %0d result words; input held off for %0d cycles",
			results_checked, input_stall_cycles);
		if (check_failures == 0 && results_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#(RunLimit);
		$display("run did not complete in time");
		$display("status: fail");
		$finish;
	end

endmodule
